[design/smf_pkg.sv]
// Shared types and constants for the sliding window median filter.
package smf_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int CFG_W        = 5;
    localparam int RESET_LENGTH = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic clear;
        logic step;
    } t_cell_ctrl;

endpackage

[design/smf_cell.sv]
// One cell of the sorted window chain: holds a sample and the ring slot it came from.
module smf_cell
    import smf_pkg::*;
#(
    parameter int SLOT_W = 4
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_active,
    input  logic [SLOT_W-1:0] i_init_slot,
    input  t_sample           i_sample,
    input  logic [SLOT_W-1:0] i_wpos,
    input  t_sample           i_prev_val,
    input  logic [SLOT_W-1:0] i_prev_slot,
    input  logic              i_prev_gt,
    input  logic              i_prev_del,
    input  t_sample           i_next_val,
    input  logic [SLOT_W-1:0] i_next_slot,
    input  logic              i_next_gt,
    output t_sample           o_val,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_gt,
    output logic              o_del,
    output t_sample           o_next_val
);

    t_sample           r_val;
    logic [SLOT_W-1:0] r_slot;
    t_sample           n_val;
    logic [SLOT_W-1:0] n_slot;

    logic              gt_own;
    logic              del_le;
    t_sample           rem_val;
    logic [SLOT_W-1:0] rem_slot;
    logic              rem_gt;
    t_sample           rem_prev_val;
    logic [SLOT_W-1:0] rem_prev_slot;
    logic              rem_prev_gt;

    // Inactive cells lie beyond the window and compare as larger than anything.
    assign gt_own = !i_active || (r_val > i_sample);
    assign del_le = i_prev_del || (i_active && (r_slot == i_wpos));

    // Contents after the oldest sample leaves the chain.
    assign rem_val       = del_le ? i_next_val  : r_val;
    assign rem_slot      = del_le ? i_next_slot : r_slot;
    assign rem_gt        = del_le ? i_next_gt   : gt_own;
    assign rem_prev_val  = i_prev_del ? r_val  : i_prev_val;
    assign rem_prev_slot = i_prev_del ? r_slot : i_prev_slot;
    assign rem_prev_gt   = i_prev_del ? gt_own : i_prev_gt;

    // The new sample enters where the chain crosses from smaller to larger.
    always_comb begin
        if (!rem_gt) begin
            n_val  = rem_val;
            n_slot = rem_slot;
        end else if (!rem_prev_gt) begin
            n_val  = i_sample;
            n_slot = i_wpos;
        end else begin
            n_val  = rem_prev_val;
            n_slot = rem_prev_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_val  <= '0;
            r_slot <= i_init_slot;
        end else if (i_ctrl.step && i_active) begin
            r_val  <= n_val;
            r_slot <= n_slot;
        end
    end

    assign o_val      = r_val;
    assign o_slot     = r_slot;
    assign o_gt       = gt_own;
    assign o_del      = del_le;
    assign o_next_val = n_val;

endmodule

[design/sliding_window_median_filter_top.sv]
// Sliding window median filter: sorted chain of cells with ring slot tags.
//
// The filter accepts one signed sample per clock cycle while the output is not stalled and
// returns, in the cycle after the transaction, the element at index length/2 of the window
// sorted ascending (the upper middle for even lengths). Each cell of the chain compares its value
// with the new sample and its neighbors, so the oldest sample leaves as the new one enters; that
// compare-and-shift step and the selection of the middle cell set the clock period. Writing
// the window length clears the window to zeros and restarts the ring position, so the first
// results after a reset or a length write include those zeros. A length of zero acts as one
// and a length at or above MAX_WINDOW acts as MAX_WINDOW; reset sets 16, capped at MAX_WINDOW.
module sliding_window_median_filter_top
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_window_length_we,
    input  logic [CFG_W-1:0] i_window_length,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_sample          i_sample,
    output logic             o_valid,
    input  logic             i_ready,
    output t_sample          o_median
);

    localparam int IW        = $clog2(MAX_WINDOW);
    localparam int LW        = $clog2(MAX_WINDOW + 1);
    localparam int RESET_LEN = (RESET_LENGTH >= MAX_WINDOW) ? MAX_WINDOW : RESET_LENGTH;

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [IW-1:0] r_wpos;
    logic [LW-1:0] wpos_inc;
    logic [LW-1:0] half;
    logic          r_ovalid;
    t_sample       r_median;
    logic          accept;
    t_cell_ctrl    ctrl;

    t_sample       c_val      [MAX_WINDOW];
    logic [IW-1:0] c_slot     [MAX_WINDOW];
    logic          c_gt       [MAX_WINDOW];
    logic          c_del      [MAX_WINDOW];
    t_sample       c_next_val [MAX_WINDOW];

    assign o_ready = i_rst_n && (!r_ovalid || i_ready);
    assign accept  = i_valid && o_ready;

    assign ctrl.clear = !i_rst_n || i_window_length_we;
    assign ctrl.step  = accept;

    always_comb begin
        if (32'(i_window_length) >= 32'(MAX_WINDOW)) begin
            n_len = LW'(MAX_WINDOW);
        end else if (i_window_length == '0) begin
            n_len = LW'(1);
        end else begin
            n_len = LW'(i_window_length);
        end
    end

    assign wpos_inc = LW'(r_wpos) + LW'(1);
    assign half     = r_len >> 1;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            t_sample       prev_val;
            logic [IW-1:0] prev_slot;
            logic          prev_gt;
            logic          prev_del;
            t_sample       next_val;
            logic [IW-1:0] next_slot;
            logic          next_gt;
            logic          active;

            if (gi == 0) begin : g_first
                assign prev_val  = '0;
                assign prev_slot = '0;
                assign prev_gt   = 1'b0;
                assign prev_del  = 1'b0;
            end else begin : g_mid_prev
                assign prev_val  = c_val[gi-1];
                assign prev_slot = c_slot[gi-1];
                assign prev_gt   = c_gt[gi-1];
                assign prev_del  = c_del[gi-1];
            end

            if (gi == MAX_WINDOW - 1) begin : g_last
                assign next_val  = '0;
                assign next_slot = '0;
                assign next_gt   = 1'b1;
            end else begin : g_mid_next
                assign next_val  = c_val[gi+1];
                assign next_slot = c_slot[gi+1];
                assign next_gt   = c_gt[gi+1];
            end

            assign active = LW'(gi) < r_len;

            smf_cell #(
                .SLOT_W (IW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_active    (active),
                .i_init_slot (IW'(gi)),
                .i_sample    (i_sample),
                .i_wpos      (r_wpos),
                .i_prev_val  (prev_val),
                .i_prev_slot (prev_slot),
                .i_prev_gt   (prev_gt),
                .i_prev_del  (prev_del),
                .i_next_val  (next_val),
                .i_next_slot (next_slot),
                .i_next_gt   (next_gt),
                .o_val       (c_val[gi]),
                .o_slot      (c_slot[gi]),
                .o_gt        (c_gt[gi]),
                .o_del       (c_del[gi]),
                .o_next_val  (c_next_val[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LW'(RESET_LEN);
            r_wpos   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_window_length_we) begin
                r_len  <= n_len;
                r_wpos <= '0;
            end else if (accept) begin
                if (wpos_inc >= r_len) begin
                    r_wpos <= '0;
                end else begin
                    r_wpos <= wpos_inc[IW-1:0];
                end
            end
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_median <= c_next_val[half[IW-1:0]];
        end
    end

    assign o_valid  = r_ovalid;
    assign o_median = r_median;

endmodule

[design/smf_checker.sv]
// Port-level checker for the sliding window median filter and its bind statement.
module smf_checker
    import smf_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_valid,
    input logic    o_ready,
    input logic    o_valid,
    input logic    i_ready,
    input t_sample o_median
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_transaction_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("Accepted transaction produced no result.");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !(i_valid && o_ready)) |=> !o_valid)
        else $error("Result appeared without an accepted transaction.");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_median)))
        else $error("Stalled result changed or dropped.");

endmodule

bind sliding_window_median_filter_top smf_checker u_smf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_median (o_median)
);
